@@ design/iog_pkg.sv @@
// Shared types and constants for the interval overlap grouper.
`timescale 1ns / 1ps
`default_nettype none

package iog_pkg;

  // Result field widths, fixed by the transaction format
  localparam int BIDX_W = 6;
  localparam int BCNT_W = 7;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the input transaction, rewind the scan
    logic step;    // advance the read/compare pipeline by one entry
    logic finish;  // commit table update and load the result register
  } iog_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic hit;       // entry under compare overlaps the interval
    logic drained;   // every used entry compared, nothing found
    logic out_free;  // result register can take a new result this cycle
  } iog_stat_t;

endpackage

`default_nettype wire

@@ design/iog_ctrl.sv @@
// Sequencing state machine for the interval overlap grouper.
`timescale 1ns / 1ps
`default_nettype none

module iog_ctrl import iog_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire iog_stat_t stat,
  output iog_cmd_t       cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state_r;
  logic state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.hit || stat.drained) begin
          // hold the decision until the result register is free
          if (stat.out_free) begin
            cmd.finish = 1'b1;
            state_nxt  = ST_IDLE;
          end
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ design/iog_dpath.sv @@
// Block table memory, scan pipeline, union logic and result register.
`timescale 1ns / 1ps
`default_nettype none

module iog_dpath import iog_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int POS_BITS   = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire iog_cmd_t            cmd,
  output iog_stat_t                stat,
  input  wire logic                in_start_set,
  input  wire logic [POS_BITS-1:0] in_first_pos,
  input  wire logic [POS_BITS-1:0] in_last_pos,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [BIDX_W-1:0]        out_block_index,
  output logic                     out_opened_new,
  output logic                     out_table_full,
  output logic [BCNT_W-1:0]        out_block_count
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

  // Table: {low, high} per entry
  logic [2*POS_BITS-1:0] mem [MAX_BLOCKS];

  logic [POS_BITS-1:0] lo_r, hi_r;
  logic [POS_BITS-1:0] rd_lo_r, rd_hi_r;
  logic [IDX_W-1:0]    cmp_ptr_r;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [BIDX_W-1:0]   out_idx_r;
  logic                out_new_r, out_full_r;
  logic [BCNT_W-1:0]   out_cnt_r;

  logic                rd_more, hit, room, swap;
  logic [POS_BITS-1:0] un_lo, un_hi, wr_lo, wr_hi;
  logic [IDX_W-1:0]    wr_addr, res_idx;
  logic [CNT_W-1:0]    cnt_after;
  logic [IDX_W+BIDX_W-1:0] idx_ext;
  logic [CNT_W+BCNT_W-1:0] cnt_ext;

  assign rd_more = rd_ptr_r < used_r;
  assign hit     = cmp_vld_r && (lo_r <= rd_hi_r) && (hi_r >= rd_lo_r);
  assign room    = used_r < MAX_CNT;
  assign swap    = in_last_pos < in_first_pos;

  assign stat.hit      = hit;
  assign stat.drained  = !rd_more && !cmp_vld_r;
  assign stat.out_free = !out_valid_r || out_ready;

  assign un_lo = (lo_r < rd_lo_r) ? lo_r : rd_lo_r;
  assign un_hi = (hi_r > rd_hi_r) ? hi_r : rd_hi_r;

  assign wr_addr = hit ? cmp_ptr_r : used_r[IDX_W-1:0];
  assign wr_lo   = hit ? un_lo : lo_r;
  assign wr_hi   = hit ? un_hi : hi_r;

  // dropped interval reports index zero
  assign res_idx   = hit ? cmp_ptr_r : (room ? used_r[IDX_W-1:0] : '0);
  assign cnt_after = (!hit && room) ? used_r + CNT_W'(1) : used_r;

  assign idx_ext = {{BIDX_W{1'b0}}, res_idx};
  assign cnt_ext = {{BCNT_W{1'b0}}, cnt_after};

  always_comb begin
    used_nxt      = used_r;
    rd_ptr_nxt    = rd_ptr_r;
    cmp_vld_nxt   = cmp_vld_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load) begin
      used_nxt    = in_start_set ? '0 : used_r;
      rd_ptr_nxt  = '0;
      cmp_vld_nxt = 1'b0;
    end
    if (cmd.step) begin
      cmp_vld_nxt = rd_more;
      if (rd_more) begin
        rd_ptr_nxt = rd_ptr_r + CNT_W'(1);
      end
    end
    if (cmd.finish) begin
      used_nxt      = cnt_after;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      rd_ptr_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      used_r      <= used_nxt;
      rd_ptr_r    <= rd_ptr_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers and table memory
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo_r <= swap ? in_last_pos : in_first_pos;
      hi_r <= swap ? in_first_pos : in_last_pos;
    end
    if (cmd.step && rd_more) begin
      {rd_lo_r, rd_hi_r} <= mem[rd_ptr_r[IDX_W-1:0]];
      cmp_ptr_r          <= rd_ptr_r[IDX_W-1:0];
    end
    if (cmd.finish && (hit || room)) begin
      mem[wr_addr] <= {wr_lo, wr_hi};
    end
    if (cmd.finish) begin
      out_idx_r  <= idx_ext[BIDX_W-1:0];
      out_new_r  <= !hit && room;
      out_full_r <= !hit && !room;
      out_cnt_r  <= cnt_ext[BCNT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_block_index = out_idx_r;
  assign out_opened_new  = out_new_r;
  assign out_table_full  = out_full_r;
  assign out_block_count = out_cnt_r;

endmodule

`default_nettype wire

@@ design/interval_overlap_grouper_unit.sv @@
// Top level of the interval overlap grouper: controller plus table datapath.
// Scan: the single table read port feeds one compare per cycle, entries in order; a
//   transaction finishes at its first overlapping block, after all n blocks on a miss, and
//   without any compare on an empty table. One transaction is handled at a time, the next
//   is taken only in idle; a waiting result stalls only the finish step.
// Reset (rst_n, synchronous, active low) empties the table and clears all handshakes.
`timescale 1ns / 1ps
`default_nettype none

module interval_overlap_grouper_unit import iog_pkg::*; #(
  parameter int MAX_BLOCKS = 64,
  parameter int POS_BITS   = 32
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input channel
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_start_set,
  input  wire logic [POS_BITS-1:0] in_first_pos,
  input  wire logic [POS_BITS-1:0] in_last_pos,
  // result channel
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [BIDX_W-1:0]        out_block_index,
  output logic                     out_opened_new,
  output logic                     out_table_full,
  output logic [BCNT_W-1:0]        out_block_count
);

  iog_cmd_t  cmd;
  iog_stat_t stat;

  // Controller: accepts a transaction in idle, steps the scan, then commits the
  // result once the output register has room.
  iog_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: block table in a one-read-port memory, read one entry per cycle
  // and compared in the cycle after (fully inclusive overlap test); the first hit
  // is widened to the union, a miss opens the next free slot or drops if full.
  iog_dpath #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .POS_BITS   (POS_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_start_set    (in_start_set),
    .in_first_pos    (in_first_pos),
    .in_last_pos     (in_last_pos),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_block_index (out_block_index),
    .out_opened_new  (out_opened_new),
    .out_table_full  (out_table_full),
    .out_block_count (out_block_count)
  );

endmodule

`default_nettype wire

@@ design/iog_checker.sv @@
// Port-level assertions for the interval overlap grouper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module iog_checker import iog_pkg::*; (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [BIDX_W-1:0] out_block_index,
  input wire logic              out_opened_new,
  input wire logic              out_table_full
);

  // a stalled result transaction stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // an accepted transaction always occupies the unit for the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again straight after a transaction");

  a_new_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_opened_new && out_table_full))
    else $error("new block and full table flagged together");

  a_full_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_block_index == '0)
    else $error("dropped interval reports a non-zero index");

endmodule

bind interval_overlap_grouper_unit iog_checker u_iog_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_block_index (out_block_index),
  .out_opened_new  (out_opened_new),
  .out_table_full  (out_table_full)
);

`default_nettype wire
